// File: sv/thcomp_pkg.sv
// shared types and constants for the temperature / humidity compensation core
// no dependencies; imported by every module of the block
`default_nettype none

package thcomp_pkg;

    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned CfgDataW = 24;

    // register indexes of the calibration port
    localparam logic [CfgAddrW-1:0] REG_CAL_T1    = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_CAL_T2    = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_CAL_T3    = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_CAL_H1    = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_CAL_H2    = 3'd4;
    localparam logic [CfgAddrW-1:0] REG_CAL_H3    = 3'd5;
    localparam logic [CfgAddrW-1:0] REG_CAL_H4_H5 = 3'd6;
    localparam logic [CfgAddrW-1:0] REG_CAL_H6    = 3'd7;

    // formula constants
    localparam logic signed [31:0] FINE_T_OFFSET = 32'sd76800;
    localparam logic signed [31:0] HUM_A_ROUND   = 32'sd16384;
    localparam logic signed [31:0] HUM_C_OFFSET  = 32'sd32768;
    localparam logic signed [31:0] HUM_E_OFFSET  = 32'sd2097152;
    localparam logic signed [31:0] HUM_E_ROUND   = 32'sd8192;
    localparam logic signed [31:0] HUM_MAX       = 32'sd419430400;
    localparam logic signed [35:0] TEMP_ROUND    = 36'sd128;
    localparam logic signed [35:0] TEMP_SCALE    = 36'sd5;
    localparam logic signed [35:0] TEMP_SAT_HI   = 36'sd8388607;
    localparam logic signed [35:0] TEMP_SAT_LO   = -36'sd8388608;
    localparam logic [16:0]        HUM_Q10_MAX   = 17'd102400;

    // calibration words as the datapath sees them
    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [7:0]  h1;
        logic signed [15:0] h2;
        logic        [7:0]  h3;
        logic signed [11:0] h4;
        logic signed [11:0] h5;
        logic signed [7:0]  h6;
    } t_cal;

    // temperature results handed to the humidity section
    typedef struct packed {
        logic signed [31:0] fine;
        logic signed [23:0] temp;
        logic        [15:0] adc_hum;
    } t_temp_res;

endpackage

`default_nettype wire

// File: sv/thcomp_cfg_regs.sv
// calibration register file of the compensation core
// depends on thcomp_pkg for register indexes and the t_cal struct
`default_nettype none

module thcomp_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [thcomp_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  wire logic [thcomp_pkg::CfgDataW-1:0] i_cfg_wdata,
    output      thcomp_pkg::t_cal              o_cal
);
    import thcomp_pkg::*;

    t_cal r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_CAL_T1:    r_cal.t1 <= i_cfg_wdata[15:0];
                REG_CAL_T2:    r_cal.t2 <= $signed(i_cfg_wdata[15:0]);
                REG_CAL_T3:    r_cal.t3 <= $signed(i_cfg_wdata[15:0]);
                REG_CAL_H1:    r_cal.h1 <= i_cfg_wdata[7:0];
                REG_CAL_H2:    r_cal.h2 <= $signed(i_cfg_wdata[15:0]);
                REG_CAL_H3:    r_cal.h3 <= i_cfg_wdata[7:0];
                REG_CAL_H4_H5: begin
                    r_cal.h4 <= $signed(i_cfg_wdata[23:12]);
                    r_cal.h5 <= $signed(i_cfg_wdata[11:0]);
                end
                REG_CAL_H6:    r_cal.h6 <= $signed(i_cfg_wdata[7:0]);
            endcase
        end
    end

    assign o_cal = r_cal;

endmodule

`default_nettype wire

// File: sv/thcomp_temp_pipe.sv
// three-stage temperature section: fine temperature and saturated centidegrees
// depends on thcomp_pkg for t_cal, t_temp_res and formula constants
`default_nettype none

module thcomp_temp_pipe (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [19:0]           i_adc_temp,
    input  wire logic [15:0]           i_adc_hum,
    input  wire thcomp_pkg::t_cal      i_cal,
    input  wire logic                  i_en_dn,
    output      logic                  o_en_up,
    output      logic                  o_valid,
    output      thcomp_pkg::t_temp_res o_res
);
    import thcomp_pkg::*;

    logic [2:0] r_v;
    logic       en1, en2, en3;

    // stage registers
    logic signed [31:0] r_p1, r_dd;
    logic        [15:0] r_hum1;
    logic signed [31:0] r_var1, r_q;
    logic        [15:0] r_hum2;
    t_temp_res          r_res;

    // sign / zero extended calibration words
    logic signed [31:0] t1x, t2x, t3x;
    logic signed [31:0] tx3, tx4, diff1, d;
    logic signed [31:0] n_p1, n_dd, n_var1, n_q;
    logic signed [31:0] var2, tf;
    logic signed [35:0] tf_x, t_full;
    logic signed [23:0] n_temp;

    assign en3 = !r_v[2] || i_en_dn;
    assign en2 = !r_v[1] || en3;
    assign en1 = !r_v[0] || en2;
    assign o_en_up = en1;

    assign t1x = $signed({16'd0, i_cal.t1});
    assign t2x = $signed({{16{i_cal.t2[15]}}, i_cal.t2});
    assign t3x = $signed({{16{i_cal.t3[15]}}, i_cal.t3});

    // stage 1: the two independent products
    always_comb begin
        tx3   = $signed({15'd0, i_adc_temp[19:3]});
        tx4   = $signed({16'd0, i_adc_temp[19:4]});
        diff1 = tx3 - (t1x <<< 1);
        d     = tx4 - t1x;
        n_p1  = diff1 * t2x;
        n_dd  = d * d;
    end

    // stage 2: scale and the cubic-term product
    always_comb begin
        n_var1 = r_p1 >>> 11;
        n_q    = (r_dd >>> 12) * t3x;
    end

    // stage 3: fine temperature and the saturated centidegree value
    always_comb begin
        var2   = r_q >>> 14;
        tf     = r_var1 + var2;
        tf_x   = $signed({{4{tf[31]}}, tf});
        t_full = (tf_x * TEMP_SCALE + TEMP_ROUND) >>> 8;
        if (t_full > TEMP_SAT_HI) begin
            n_temp = TEMP_SAT_HI[23:0];
        end else if (t_full < TEMP_SAT_LO) begin
            n_temp = TEMP_SAT_LO[23:0];
        end else begin
            n_temp = t_full[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en1) r_v[0] <= i_valid;
            if (en2) r_v[1] <= r_v[0];
            if (en3) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_p1   <= n_p1;
            r_dd   <= n_dd;
            r_hum1 <= i_adc_hum;
        end
        if (en2) begin
            r_var1 <= n_var1;
            r_q    <= n_q;
            r_hum2 <= r_hum1;
        end
        if (en3) begin
            r_res.fine    <= tf;
            r_res.temp    <= n_temp;
            r_res.adc_hum <= r_hum2;
        end
    end

    assign o_valid = r_v[2];
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_en_up |=> r_v[0])
        else $error("accepted reading did not enter the first stage");
`endif

endmodule

`default_nettype wire

// File: sv/thcomp_hum_pipe.sv
// seven-stage humidity section with the output register of the core
// depends on thcomp_pkg for t_cal, t_temp_res and formula constants
`default_nettype none

module thcomp_hum_pipe (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire thcomp_pkg::t_temp_res i_res,
    input  wire thcomp_pkg::t_cal      i_cal,
    input  wire logic                  i_stall,
    output      logic                  o_en_up,
    output      logic                  o_valid,
    output      logic signed [23:0]    o_temp_centi,
    output      logic signed [31:0]    o_fine_temp,
    output      logic        [16:0]    o_hum_q10
);
    import thcomp_pkg::*;

    logic [6:0] r_v;
    logic [6:0] en;

    // temperature results ride alongside
    logic signed [31:0] r_fine [6];
    logic signed [23:0] r_temp [6];

    logic signed [31:0] r_m6, r_m3, r_h5v;
    logic        [15:0] r_hum;
    logic signed [31:0] r_e1, r_a5;
    logic signed [31:0] r_e3, r_a6;
    logic signed [31:0] r_v7;
    logic signed [31:0] r_bb, r_v8;
    logic signed [31:0] r_c2, r_v9;
    logic signed [31:0] r_out_fine;
    logic signed [23:0] r_out_temp;
    logic        [16:0] r_out_hum;

    logic signed [31:0] h1x, h2x, h3x, h4x, h5x, h6x;
    logic signed [31:0] v, n_m6, n_m3, n_h5v;
    logic signed [31:0] b, c, n_e1, adch, n_a5;
    logic signed [31:0] e2, n_e3;
    logic signed [31:0] e, n_v7;
    logic signed [31:0] b2, n_bb;
    logic signed [31:0] c1, n_c2;
    logic signed [31:0] v3;
    logic        [16:0] n_hum;

    assign en[6] = !r_v[6] || !i_stall;
    assign en[5] = !r_v[5] || en[6];
    assign en[4] = !r_v[4] || en[5];
    assign en[3] = !r_v[3] || en[4];
    assign en[2] = !r_v[2] || en[3];
    assign en[1] = !r_v[1] || en[2];
    assign en[0] = !r_v[0] || en[1];
    assign o_en_up = en[0];

    assign h1x = $signed({24'd0, i_cal.h1});
    assign h2x = $signed({{16{i_cal.h2[15]}}, i_cal.h2});
    assign h3x = $signed({24'd0, i_cal.h3});
    assign h4x = $signed({{20{i_cal.h4[11]}}, i_cal.h4});
    assign h5x = $signed({{20{i_cal.h5[11]}}, i_cal.h5});
    assign h6x = $signed({{24{i_cal.h6[7]}}, i_cal.h6});

    // offset fine temperature and its three products
    always_comb begin
        v     = i_res.fine - FINE_T_OFFSET;
        n_m6  = v * h6x;
        n_m3  = v * h3x;
        n_h5v = v * h5x;
    end

    // raw term and the temperature dependent gain product
    always_comb begin
        b    = r_m6 >>> 10;
        c    = (r_m3 >>> 11) + HUM_C_OFFSET;
        n_e1 = b * c;
        adch = $signed({16'd0, r_hum});
        n_a5 = ((adch <<< 14) - (h4x <<< 20) - r_h5v + HUM_A_ROUND) >>> 15;
    end

    always_comb begin
        e2   = (r_e1 >>> 10) + HUM_E_OFFSET;
        n_e3 = e2 * h2x + HUM_E_ROUND;
    end

    always_comb begin
        e    = r_e3 >>> 14;
        n_v7 = r_a6 * e;
    end

    // square term for the high-humidity correction
    always_comb begin
        b2   = r_v7 >>> 15;
        n_bb = b2 * b2;
    end

    always_comb begin
        c1   = r_bb >>> 7;
        n_c2 = c1 * h1x;
    end

    // correction, clamp to 0..100 %RH and drop the fraction bits
    always_comb begin
        v3 = r_v9 - (r_c2 >>> 4);
        if (v3 < 32'sd0) begin
            n_hum = '0;
        end else if (v3 > HUM_MAX) begin
            n_hum = HUM_MAX[28:12];
        end else begin
            n_hum = v3[28:12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
            if (en[3]) r_v[3] <= r_v[2];
            if (en[4]) r_v[4] <= r_v[3];
            if (en[5]) r_v[5] <= r_v[4];
            if (en[6]) r_v[6] <= r_v[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_m6     <= n_m6;
            r_m3     <= n_m3;
            r_h5v    <= n_h5v;
            r_hum    <= i_res.adc_hum;
            r_fine[0] <= i_res.fine;
            r_temp[0] <= i_res.temp;
        end
        if (en[1]) begin
            r_e1      <= n_e1;
            r_a5      <= n_a5;
            r_fine[1] <= r_fine[0];
            r_temp[1] <= r_temp[0];
        end
        if (en[2]) begin
            r_e3      <= n_e3;
            r_a6      <= r_a5;
            r_fine[2] <= r_fine[1];
            r_temp[2] <= r_temp[1];
        end
        if (en[3]) begin
            r_v7      <= n_v7;
            r_fine[3] <= r_fine[2];
            r_temp[3] <= r_temp[2];
        end
        if (en[4]) begin
            r_bb      <= n_bb;
            r_v8      <= r_v7;
            r_fine[4] <= r_fine[3];
            r_temp[4] <= r_temp[3];
        end
        if (en[5]) begin
            r_c2      <= n_c2;
            r_v9      <= r_v8;
            r_fine[5] <= r_fine[4];
            r_temp[5] <= r_temp[4];
        end
        if (en[6]) begin
            r_out_hum  <= n_hum;
            r_out_fine <= r_fine[5];
            r_out_temp <= r_temp[5];
        end
    end

    assign o_valid      = r_v[6];
    assign o_temp_centi = r_out_temp;
    assign o_fine_temp  = r_out_fine;
    assign o_hum_q10    = r_out_hum;

`ifndef SYNTHESIS
    a_hum_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hum_q10 <= HUM_Q10_MAX)
        else $error("humidity result above full scale");
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled result dropped from output register");
    a_fill_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[5] && !r_v[6] |=> r_v[6])
        else $error("finished item did not move into empty output register");
`endif

endmodule

`default_nettype wire

// File: sv/env_sensor_temp_hum_compensation_core.sv
// top level of the temperature / humidity compensation core
// depends on thcomp_pkg, thcomp_cfg_regs, thcomp_temp_pipe and thcomp_hum_pipe
`default_nettype none

// Integer compensation of one raw 20-bit temperature and one raw 16-bit humidity
// reading per transfer, using the eight factory calibration registers. Each result
// carries temperature in 0.01 degree steps (saturated to 24 bits), the 32-bit fine
// temperature and humidity in 1/1024 %RH clamped to 0..102400. The datapath is a
// ten-stage pipeline, one 32-bit multiply level per stage at most: three stages
// for temperature, seven for humidity, the last being the output register. A new
// reading is taken every cycle; a stalled output only holds back the input once
// every stage holding data is full, since empty stages keep closing up.
// Calibration writes take effect at the next clock and should be made while no
// reading is in flight.

module env_sensor_temp_hum_compensation_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // sample input
    input  wire logic                            i_valid,
    output      logic                            o_stall,
    input  wire logic [19:0]                     i_adc_temp,
    input  wire logic [15:0]                     i_adc_hum,
    // calibration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [thcomp_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  wire logic [thcomp_pkg::CfgDataW-1:0] i_cfg_wdata,
    // result output
    output      logic                            o_valid,
    input  wire logic                            i_stall,
    output      logic signed [23:0]              o_temp_centi,
    output      logic signed [31:0]              o_fine_temp,
    output      logic        [16:0]              o_hum_q10
);
    import thcomp_pkg::*;

    t_cal      cal;
    t_temp_res temp_res;
    logic      temp_valid;
    logic      temp_en_up;
    logic      hum_en_up;

    // calibration words, held until rewritten
    thcomp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cal       (cal)
    );

    // temperature section, feeds the fine temperature forward
    thcomp_temp_pipe u_temp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_adc_temp (i_adc_temp),
        .i_adc_hum  (i_adc_hum),
        .i_cal      (cal),
        .i_en_dn    (hum_en_up),
        .o_en_up    (temp_en_up),
        .o_valid    (temp_valid),
        .o_res      (temp_res)
    );

    // humidity section ending in the output register
    thcomp_hum_pipe u_hum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (temp_valid),
        .i_res        (temp_res),
        .i_cal        (cal),
        .i_stall      (i_stall),
        .o_en_up      (hum_en_up),
        .o_valid      (o_valid),
        .o_temp_centi (o_temp_centi),
        .o_fine_temp  (o_fine_temp),
        .o_hum_q10    (o_hum_q10)
    );

    // input held off only when the first stage cannot move on
    assign o_stall = !temp_en_up;

endmodule

`default_nettype wire

// File: verif/thcomp_checker.sv
`timescale 1ns / 1ps
// result checker for the temperature / humidity compensation core: keeps its own copy of the
// calibration registers, predicts each accepted reading and compares results in order
// depends on thcomp_pkg for register indexes, formula constants and the calibration struct

module thcomp_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [19:0]                     i_adc_temp,
    input  logic [15:0]                     i_adc_hum,
    input  logic                            i_cfg_we,
    input  logic [thcomp_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  logic [thcomp_pkg::CfgDataW-1:0] i_cfg_wdata,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic signed [23:0]              i_temp_centi,
    input  logic signed [31:0]              i_fine_temp,
    input  logic        [16:0]              i_hum_q10,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked
);
    import thcomp_pkg::*;

    localparam int ReportLimit = 10;

    typedef struct packed {
        logic signed [23:0] temp_centi;
        logic signed [31:0] fine_temp;
        logic        [16:0] hum_q10;
    } t_reading;

    t_cal     cal_copy;
    t_reading expected_readings [$];
    t_reading want;
    int       fails    = 0;
    int       reported = 0;
    int       checked  = 0;

    // keep the low 32 bits as a signed value
    function automatic longint fold32(input longint x);
        int w;
        w = x[31:0];
        return longint'(w);
    endfunction

    function automatic t_reading compensate(input t_cal cal, input logic [19:0] adc_temp,
                                            input logic [15:0] adc_hum);
        longint   adc_t, adc_h, t1, t2, t3, h1, h2, h3, h4, h5, h6;
        longint   var1, var2, d, tf, temp, v, a, b, c, e;
        t_reading r;
        adc_t = longint'(adc_temp);
        adc_h = longint'(adc_hum);
        t1    = longint'(cal.t1);
        t2    = longint'($signed(cal.t2));
        t3    = longint'($signed(cal.t3));
        h1    = longint'(cal.h1);
        h2    = longint'($signed(cal.h2));
        h3    = longint'(cal.h3);
        h4    = longint'($signed(cal.h4));
        h5    = longint'($signed(cal.h5));
        h6    = longint'($signed(cal.h6));

        // temperature, every intermediate wrapped to 32 bits
        var1 = fold32(((adc_t >>> 3) - t1 * 2) * t2) >>> 11;
        d    = (adc_t >>> 4) - t1;
        var2 = fold32((fold32(d * d) >>> 12) * t3) >>> 14;
        tf   = fold32(var1 + var2);
        // scaling to hundredths is done wide, then saturated
        temp = (tf * 5 + 128) >>> 8;
        if (temp > longint'(TEMP_SAT_HI)) temp = longint'(TEMP_SAT_HI);
        if (temp < longint'(TEMP_SAT_LO)) temp = longint'(TEMP_SAT_LO);

        // humidity
        v = fold32(tf - longint'(FINE_T_OFFSET));
        a = fold32(adc_h * 16384 - h4 * 1048576 - h5 * v + longint'(HUM_A_ROUND)) >>> 15;
        b = fold32(v * h6) >>> 10;
        c = (fold32(v * h3) >>> 11) + longint'(HUM_C_OFFSET);
        e = fold32(b * c) >>> 10;
        e = fold32(e + longint'(HUM_E_OFFSET));
        e = fold32(e * h2 + longint'(HUM_E_ROUND)) >>> 14;
        v = fold32(a * e);
        b = v >>> 15;
        c = fold32(b * b) >>> 7;
        c = fold32(c * h1) >>> 4;
        v = fold32(v - c);
        if (v < 0) v = 0;
        if (v > longint'(HUM_MAX)) v = longint'(HUM_MAX);

        r.temp_centi = temp[23:0];
        r.fine_temp  = tf[31:0];
        r.hum_q10    = v[28:12];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cal_copy = '0;
            expected_readings.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_readings.size() == 0) begin
                    fails++;
                    if (reported < ReportLimit) begin
                        reported++;
                        $display("error: unexpected result temp %0d fine %0d hum %0d",
                                 i_temp_centi, i_fine_temp, i_hum_q10);
                    end
                end else begin
                    want = expected_readings.pop_front();
                    checked++;
                    if (i_temp_centi !== want.temp_centi || i_fine_temp !== want.fine_temp ||
                        i_hum_q10 !== want.hum_q10) begin
                        fails++;
                        if (reported < ReportLimit) begin
                            reported++;
                            $display("error: result %0d exp temp %0d fine %0d hum %0d",
                                     checked, want.temp_centi, want.fine_temp, want.hum_q10);
                            $display("       got temp %0d fine %0d hum %0d",
                                     i_temp_centi, i_fine_temp, i_hum_q10);
                        end
                    end
                end
            end
            // prediction uses the registers as they stood before this edge
            if (i_in_valid && !i_in_stall)
                expected_readings.push_back(compensate(cal_copy, i_adc_temp, i_adc_hum));
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_CAL_T1:    cal_copy.t1 = i_cfg_wdata[15:0];
                    REG_CAL_T2:    cal_copy.t2 = i_cfg_wdata[15:0];
                    REG_CAL_T3:    cal_copy.t3 = i_cfg_wdata[15:0];
                    REG_CAL_H1:    cal_copy.h1 = i_cfg_wdata[7:0];
                    REG_CAL_H2:    cal_copy.h2 = i_cfg_wdata[15:0];
                    REG_CAL_H3:    cal_copy.h3 = i_cfg_wdata[7:0];
                    REG_CAL_H4_H5: begin
                        cal_copy.h4 = i_cfg_wdata[23:12];
                        cal_copy.h5 = i_cfg_wdata[11:0];
                    end
                    REG_CAL_H6:    cal_copy.h6 = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_readings.size();
        o_checked    <= checked;
    end

endmodule

// File: verif/tb_env_sensor_temp_hum_compensation_core.sv
`timescale 1ns / 1ps
// testbench top for the temperature / humidity compensation core: clock, reset, calibration
// writes, reading stimulus with random idling, and the final verdict
// depends on thcomp_pkg, env_sensor_temp_hum_compensation_core and thcomp_checker

module tb_env_sensor_temp_hum_compensation_core;
    import thcomp_pkg::*;

    // calibration sets the run goes through
    typedef enum int {
        CAL_ZERO,
        CAL_TYPICAL,
        CAL_PROBE,
        CAL_MAX,
        CAL_MIN,
        CAL_ONES,
        CAL_NEAR,
        CAL_RANDOM
    } t_cal_kind;

    // idling patterns of the two channels
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    localparam int ItemsPerPhase = 17;
    localparam int DrainCycles   = 20;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [19:0]         adc_temp  = '0;
    logic [15:0]         adc_hum   = '0;
    logic                cfg_we    = 1'b0;
    logic [CfgAddrW-1:0] cfg_addr  = '0;
    logic [CfgDataW-1:0] cfg_wdata = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic signed [23:0]  temp_centi;
    logic signed [31:0]  fine_temp;
    logic        [16:0]  hum_q10;

    int fail_count;
    int pending;
    int checked;

    int src_pct      = 0;   // chance per cycle that the sender holds back
    int sink_pct     = 0;   // chance per cycle that the receiver stalls
    int readings_sent = 0;
    int cal_settings  = 1;  // reset values count as the first setting

    logic [CfgDataW-1:0] cal_words [8];
    t_cal_kind           random_sets [8];

    env_sensor_temp_hum_compensation_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_adc_temp   (adc_temp),
        .i_adc_hum    (adc_hum),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_temp_centi (temp_centi),
        .o_fine_temp  (fine_temp),
        .o_hum_q10    (hum_q10)
    );

    thcomp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_adc_temp   (adc_temp),
        .i_adc_hum    (adc_hum),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_temp_centi (temp_centi),
        .i_fine_temp  (fine_temp),
        .i_hum_q10    (hum_q10),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 12 ns clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // receiver back-pressure, independent of the result valid
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(0, 99) < sink_pct);
    end

    // one reading transfer, with a random gap in front of it; valid stays high
    // from one reading to the next when there is no gap
    task automatic send_reading(input logic [19:0] t, input logic [15:0] h);
        while ($urandom_range(0, 99) < src_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        adc_temp <= t;
        adc_hum  <= h;
        do @(posedge i_clk); while (in_stall);
        readings_sent++;
    endtask

    // extreme combinations of the two raw fields
    task automatic send_corners();
        send_reading('0, '0);
        send_reading('1, '1);
        send_reading('0, '1);
        send_reading('1, '0);
    endtask

    // lower valid and wait until every predicted result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // choose a calibration set and write all eight registers back to back;
    // bits above each register's width carry junk that must be ignored
    task automatic program_cal(input t_cal_kind kind);
        int t1, t2, t3, h1, h2, h3, h4, h5, h6;
        // published example calibration as the default
        t1 = 27504; t2 = 26435; t3 = -1000;
        h1 = 75; h2 = 362; h3 = 0; h4 = 324; h5 = 50; h6 = 30;
        case (kind)
            CAL_ZERO: begin
                t1 = 0; t2 = 0; t3 = 0; h1 = 0; h2 = 0; h3 = 0; h4 = 0; h5 = 0; h6 = 0;
            end
            CAL_PROBE: begin
                // t1 and t3 zero so that fine temperature is a plain product of t2
                t1 = 0; t2 = 20480; t3 = 0;
            end
            CAL_MAX: begin
                t1 = 65535; t2 = 32767; t3 = 32767;
                h1 = 255; h2 = 32767; h3 = 255; h4 = 2047; h5 = 2047; h6 = 127;
            end
            CAL_MIN: begin
                t1 = 0; t2 = -32768; t3 = -32768;
                h1 = 0; h2 = -32768; h3 = 0; h4 = -2048; h5 = -2048; h6 = -128;
            end
            CAL_ONES: begin
                t1 = -1; t2 = -1; t3 = -1; h1 = -1; h2 = -1; h3 = -1; h4 = -1; h5 = -1; h6 = -1;
            end
            CAL_NEAR: begin
                // small spread around the example keeps humidity inside its range
                t1 += $urandom_range(0, 4000) - 2000;
                t2 += $urandom_range(0, 4000) - 2000;
                t3 += $urandom_range(0, 1000) - 500;
                h1 = $urandom_range(0, 255);
                h2 = $urandom_range(200, 500);
                h3 = $urandom_range(0, 40);
                h4 = $urandom_range(250, 400);
                h5 = $urandom_range(0, 100);
                h6 = $urandom_range(0, 60);
            end
            CAL_RANDOM: begin
                t1 = $urandom; t2 = $urandom; t3 = $urandom; h1 = $urandom; h2 = $urandom;
                h3 = $urandom; h4 = $urandom; h5 = $urandom; h6 = $urandom;
            end
            default: ;
        endcase
        cal_words[REG_CAL_T1]    = {8'($urandom), 16'(t1)};
        cal_words[REG_CAL_T2]    = {8'($urandom), 16'(t2)};
        cal_words[REG_CAL_T3]    = {8'($urandom), 16'(t3)};
        cal_words[REG_CAL_H1]    = {16'($urandom), 8'(h1)};
        cal_words[REG_CAL_H2]    = {8'($urandom), 16'(h2)};
        cal_words[REG_CAL_H3]    = {16'($urandom), 8'(h3)};
        cal_words[REG_CAL_H4_H5] = {12'(h4), 12'(h5)};
        cal_words[REG_CAL_H6]    = {16'($urandom), 8'(h6)};
        for (int k = 0; k < 8; k++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CfgAddrW'(k);
            cfg_wdata <= cal_words[k];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        cal_settings++;
    endtask

    // main stimulus
    initial begin
        int          pick;
        logic [19:0] t;
        logic [15:0] h;

        random_sets = '{CAL_NEAR, CAL_RANDOM, CAL_ONES, CAL_NEAR,
                        CAL_MAX, CAL_RANDOM, CAL_MIN, CAL_NEAR};

        // single reset at the start
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling
        // reset calibration: every word zero
        send_reading('0, '0);
        send_reading('1, '1);
        send_reading(20'h80000, 16'h8000);
        wait_drained();

        // example calibration: a room-temperature reading, the field corners and a mid-scale reading
        program_cal(CAL_TYPICAL);
        send_reading(20'd519888, 16'd30000);
        send_corners();
        send_reading(20'h80000, 16'h8000);
        wait_drained();

        // fine temperature landing exactly on the humidity offset
        program_cal(CAL_PROBE);
        send_reading(20'd61440, 16'd0);
        send_reading(20'd61447, 16'hFFFF);
        send_reading(20'd61440, 16'd30000);
        wait_drained();

        // extreme calibration words drive temperature saturation and both humidity clamps
        program_cal(CAL_MAX);
        send_corners();
        wait_drained();
        program_cal(CAL_MIN);
        send_corners();

        // random part: each calibration set goes through all four idle patterns
        foreach (random_sets[s]) begin
            wait_drained();
            program_cal(random_sets[s]);
            for (int m = 0; m < 4; m++) begin
                case (t_idle_mode'((m + s) % 4))
                    IDLE_NONE:     begin src_pct = 0;  sink_pct <= 0;  end
                    IDLE_SENDER:   begin src_pct = 81; sink_pct <= 0;  end
                    IDLE_RECEIVER: begin src_pct = 0;  sink_pct <= 81; end
                    IDLE_BOTH:     begin src_pct = 6;  sink_pct <= 6;  end
                    default: ;
                endcase
                for (int k = 0; k < ItemsPerPhase; k++) begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0) begin
                        // field extremes
                        t = $urandom_range(0, 1) ? '1 : '0;
                        h = $urandom_range(0, 1) ? '1 : '0;
                    end else if (pick <= 5) begin
                        // realistic conversion results
                        t = 20'($urandom_range(470000, 570000));
                        h = 16'($urandom_range(18000, 42000));
                    end else begin
                        t = 20'($urandom);
                        h = 16'($urandom);
                    end
                    send_reading(t, h);
                end
            end
        end

        // let the pipeline empty, then a little longer for stray results
        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);

        $display("summary: %0d readings sent, %0d results compared, %0d calibration settings",
                 readings_sent, checked, cal_settings);
        $display("summary: idle patterns none, sender only, receiver only and both sides");
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #3000000;
        $display("error: timeout with %0d results outstanding", pending);
        $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
sv/thcomp_pkg.sv
sv/thcomp_cfg_regs.sv
sv/thcomp_temp_pipe.sv
sv/thcomp_hum_pipe.sv
sv/env_sensor_temp_hum_compensation_core.sv
verif/thcomp_checker.sv
verif/tb_env_sensor_temp_hum_compensation_core.sv
